// ----- hdl/mdqm_pkg.sv -----
// Shared types, codes and defaults for the multi-deque merge engine.
`timescale 1ns / 1ps
package mdqm_pkg;

  localparam int NUM_QUEUES_DEF = 16;
  localparam int CAPACITY_DEF   = 256;

  localparam logic [1:0] FN_PUSH  = 2'd0;
  localparam logic [1:0] FN_POP   = 2'd1;
  localparam logic [1:0] FN_MERGE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         queue_index;
    logic [3:0]         source_index;
    logic               side_or_reverse;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } out_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic exec;
    logic pop_capture;
    logic merge_step;
    logic fin_tgt;
    logic fin_src;
    logic load_out;
  } mdqm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pop_go;
    logic merge_go;
    logic merge_done;
    logic out_busy;
  } mdqm_stat_t;

endpackage

// ----- hdl/mdqm_ctrl.sv -----
// Sequencer for the multi-deque merge engine.
`timescale 1ns / 1ps
module mdqm_ctrl import mdqm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  mdqm_stat_t stat,
  output mdqm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_POPRD, S_MERGE, S_FIN_T, S_FIN_S, S_FINISH
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR:  cmd.clear       = 1'b1;
      S_IDLE:   cmd.accept      = in_valid;
      S_LOOKUP: cmd.exec        = 1'b1;
      S_POPRD:  cmd.pop_capture = 1'b1;
      S_MERGE:  cmd.merge_step  = 1'b1;
      S_FIN_T:  cmd.fin_tgt     = 1'b1;
      S_FIN_S:  cmd.fin_src     = 1'b1;
      S_FINISH: cmd.load_out    = !stat.out_busy;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR:  if (stat.clr_last) state <= S_IDLE;
        S_IDLE:   if (in_valid) state <= S_LOOKUP;
        S_LOOKUP: begin
          if (stat.pop_go) state <= S_POPRD;
          else if (stat.merge_go) state <= S_MERGE;
          else state <= S_FINISH;
        end
        S_POPRD:  state <= S_FINISH;
        S_MERGE:  if (stat.merge_done) state <= S_FIN_T;
        S_FIN_T:  state <= S_FIN_S;
        S_FIN_S:  state <= S_FINISH;
        S_FINISH: if (!stat.out_busy) state <= S_IDLE;
        default:  state <= S_CLEAR;
      endcase
    end
  end

endmodule

// ----- hdl/mdqm_datapath.sv -----
// Queue table, element memory, address arithmetic and result register.
`timescale 1ns / 1ps
module mdqm_datapath import mdqm_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int CAPACITY   = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  in_t        in_data,
  input  logic       out_stall,
  output logic       out_valid,
  output out_t       out_data,
  input  mdqm_cmd_t  cmd,
  output mdqm_stat_t stat
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = QW + PW;
  localparam logic [PW:0]   CAP_P = (PW + 1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);
  localparam logic [QW-1:0] LAST_Q = QW'(NUM_QUEUES - 1);

  typedef struct packed {
    logic [PW-1:0] head;
    logic [CW-1:0] fill;
  } qent_t;

  function automatic logic [15:0][QW-1:0] qmap_f();
    logic [15:0][QW-1:0] r;
    for (int i = 0; i < 16; i++) r[i] = QW'(i % NUM_QUEUES);
    return r;
  endfunction

  localparam logic [15:0][QW-1:0] QMAP = qmap_f();

  function automatic logic [PW-1:0] wrap(input logic [PW:0] x);
    return (x >= CAP_P) ? PW'(x - CAP_P) : x[PW-1:0];
  endfunction

  qent_t       qtab [NUM_QUEUES];
  logic [31:0] elem [2**AW];

  logic [1:0]    func;
  logic [QW-1:0] tq, sq;
  logic          side;
  logic [31:0]   value;
  qent_t         qt_t, qt_s;
  logic [31:0]   elem_q;
  logic [QW-1:0] clr_idx;
  logic [CW-1:0] rd_i, wr_i;
  logic          wr_valid;
  logic [1:0]    res_status;
  logic [31:0]   res_value;

  logic          full_t, empty_t, same_q, ovf, src_empty;
  logic [CW:0]   fill_sum;
  logic [1:0]    exec_status;
  logic          rd_en;
  logic [CW-1:0] rd_off;

  logic          el_we, el_re;
  logic [AW-1:0] el_waddr, el_raddr;
  logic [31:0]   el_wdata;
  logic          qt_we;
  logic [QW-1:0] qt_waddr;
  qent_t         qt_wdata;
  logic [PW-1:0] pos;

  assign full_t    = (qt_t.fill == CAP_C);
  assign empty_t   = (qt_t.fill == '0);
  assign same_q    = (tq == sq);
  assign fill_sum  = {1'b0, qt_t.fill} + {1'b0, qt_s.fill};
  assign ovf       = (fill_sum > (CW + 1)'(CAPACITY));
  assign src_empty = (qt_s.fill == '0);
  assign rd_en     = (rd_i != qt_s.fill);
  assign rd_off    = side ? (qt_s.fill - CW'(1) - rd_i) : rd_i;

  always_comb begin
    case (func)
      FN_PUSH:  exec_status = full_t ? ST_OVERFLOW : ST_OK;
      FN_POP:   exec_status = empty_t ? ST_EMPTY : ST_OK;
      FN_MERGE: exec_status = (!same_q && ovf) ? ST_OVERFLOW : ST_OK;
      default:  exec_status = ST_OK;
    endcase
  end

  assign stat.clr_last   = (clr_idx == LAST_Q);
  assign stat.pop_go     = (func == FN_POP) && !empty_t;
  assign stat.merge_go   = (func == FN_MERGE) && !same_q && !ovf && !src_empty;
  assign stat.merge_done = wr_valid && (wr_i == qt_s.fill - CW'(1));
  assign stat.out_busy   = out_valid && out_stall;

  always_comb begin
    el_we    = 1'b0;
    el_re    = 1'b0;
    el_waddr = '0;
    el_raddr = '0;
    el_wdata = value;
    qt_we    = 1'b0;
    qt_waddr = tq;
    qt_wdata = '0;
    pos      = '0;
    if (cmd.clear) begin
      qt_we    = 1'b1;
      qt_waddr = clr_idx;
    end
    if (cmd.exec) begin
      if (func == FN_PUSH && !full_t) begin
        qt_we = 1'b1;
        qt_wdata.fill = qt_t.fill + CW'(1);
        if (side) begin
          pos = wrap((PW + 1)'(qt_t.head) + (PW + 1)'(qt_t.fill));
          qt_wdata.head = qt_t.head;
        end else begin
          pos = (qt_t.head == '0) ? LAST_POS : qt_t.head - PW'(1);
          qt_wdata.head = pos;
        end
        el_we    = 1'b1;
        el_waddr = {tq, pos};
      end else if (func == FN_POP && !empty_t) begin
        qt_we = 1'b1;
        qt_wdata.fill = qt_t.fill - CW'(1);
        if (side) begin
          pos = wrap((PW + 1)'(qt_t.head) + (PW + 1)'(qt_t.fill - CW'(1)));
          qt_wdata.head = qt_t.head;
        end else begin
          pos = qt_t.head;
          qt_wdata.head = wrap((PW + 1)'(qt_t.head) + (PW + 1)'(1));
        end
        el_re    = 1'b1;
        el_raddr = {tq, pos};
      end else if (func == FN_MERGE && (same_q || (!ovf && src_empty))) begin
        // self merge or empty source: source just resets
        qt_we    = 1'b1;
        qt_waddr = sq;
      end
    end
    if (cmd.merge_step) begin
      el_re    = rd_en;
      el_raddr = {sq, wrap((PW + 1)'(qt_s.head) + (PW + 1)'(rd_off))};
      el_we    = wr_valid;
      el_waddr = {tq, wrap((PW + 1)'(qt_t.head) + (PW + 1)'(qt_t.fill + wr_i))};
      el_wdata = elem_q;
    end
    if (cmd.fin_tgt) begin
      qt_we         = 1'b1;
      qt_wdata.head = qt_t.head;
      qt_wdata.fill = qt_t.fill + qt_s.fill;
    end
    if (cmd.fin_src) begin
      qt_we    = 1'b1;
      qt_waddr = sq;
    end
  end

  always_ff @(posedge clk) begin
    if (el_we) elem[el_waddr] <= el_wdata;
    if (el_re) elem_q <= elem[el_raddr];
    if (qt_we) qtab[qt_waddr] <= qt_wdata;
    if (cmd.accept) begin
      func  <= in_data.func;
      tq    <= QMAP[in_data.queue_index];
      sq    <= QMAP[in_data.source_index];
      side  <= in_data.side_or_reverse;
      value <= in_data.push_value;
      qt_t  <= qtab[QMAP[in_data.queue_index]];
      qt_s  <= qtab[QMAP[in_data.source_index]];
    end
    if (cmd.exec) begin
      res_status <= exec_status;
      res_value  <= '0;
      rd_i       <= '0;
      wr_i       <= '0;
    end
    if (cmd.pop_capture) res_value <= elem_q;
    if (cmd.merge_step) begin
      if (rd_en) rd_i <= rd_i + CW'(1);
      if (wr_valid) wr_i <= wr_i + CW'(1);
    end
    if (cmd.load_out) out_data <= '{status: res_status, pop_value: res_value};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      wr_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) clr_idx <= clr_idx + QW'(1);
      wr_valid <= cmd.merge_step && rd_en;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_valid |-> (wr_i < qt_s.fill))
    else $error("merge write past source length");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  a_fill_cap: assert property (@(posedge clk) disable iff (rst)
    qt_we |-> (qt_wdata.fill <= CAP_C))
    else $error("queue fill beyond capacity");

endmodule

// ----- hdl/multi_deque_merge_engine.sv -----
// Top level of the multi-deque merge engine.
//
//   channel  dir  payload  handshake
//   in       in   in_t     in_valid / in_stall
//   out      out  out_t    out_valid / out_stall
//
// Push, bad pop, refused or trivial merge pass through lookup and finish;
// a pop adds a memory read state. A merge copies one word per cycle through the
// element memory's read and write ports, then updates target and source.
// After reset a clearing pass zeroes the queue table entry by entry;
// in_stall stays high during it.
// A stalled result holds in the output register; the next result waits to load.
`timescale 1ns / 1ps
module multi_deque_merge_engine import mdqm_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int CAPACITY   = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  mdqm_cmd_t  cmd;
  mdqm_stat_t stat;

  mdqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mdqm_datapath #(
    .NUM_QUEUES (NUM_QUEUES),
    .CAPACITY   (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- verif/multi_deque_merge_engine_tb.sv -----
// Self-checking testbench for the multi-deque merge engine.
`timescale 1ns / 1ps
module multi_deque_merge_engine_tb;
  import mdqm_pkg::*;

  localparam int NQ  = NUM_QUEUES_DEF;
  localparam int CAP = CAPACITY_DEF;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  multi_deque_merge_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow deques: each queue kept as an ordered list, front at index 0.
  logic signed [31:0] shadow_q [NQ][$];
  out_t               expected_results [$];
  in_t                pending_requests [$];
  int                 fail_count = 0;
  idle_mode_t         idle_mode;
  bit                 hold_recv;
  bit                 hold_send;
  bit                 in_taken;

  function automatic out_t predict_command(in_t cmd);
    out_t r;
    int tq;
    int sq;
    int n;
    logic signed [31:0] tmp [$];
    r.status = ST_OK;
    r.pop_value = '0;
    tq = cmd.queue_index % NQ;
    sq = cmd.source_index % NQ;
    case (cmd.func)
      FN_PUSH: begin
        if (shadow_q[tq].size() >= CAP) r.status = ST_OVERFLOW;
        else if (cmd.side_or_reverse) shadow_q[tq].insert(shadow_q[tq].size(), cmd.push_value);
        else shadow_q[tq].insert(0, cmd.push_value);
      end
      FN_POP: begin
        if (shadow_q[tq].size() == 0) begin
          r.status = ST_EMPTY;
        end else if (cmd.side_or_reverse) begin
          r.pop_value = shadow_q[tq][shadow_q[tq].size() - 1];
          shadow_q[tq].delete(shadow_q[tq].size() - 1);
        end else begin
          r.pop_value = shadow_q[tq][0];
          shadow_q[tq].delete(0);
        end
      end
      FN_MERGE: begin
        if (tq == sq) begin
          shadow_q[sq].delete();
        end else if (shadow_q[tq].size() + shadow_q[sq].size() > CAP) begin
          r.status = ST_OVERFLOW;
        end else begin
          tmp = shadow_q[sq];
          n = tmp.size();
          for (int i = 0; i < n; i++)
            shadow_q[tq].insert(shadow_q[tq].size(),
                                cmd.side_or_reverse ? tmp[n - 1 - i] : tmp[i]);
          shadow_q[sq].delete();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit idle_roll(bit sender);
    case (idle_mode)
      IDLE_SEND: return sender && ($urandom_range(99) < 75);
      IDLE_RECV: return !sender && ($urandom_range(99) < 75);
      IDLE_BOTH: return $urandom_range(99) < 12;
      default:   return 1'b0;
    endcase
  endfunction

  // Driver: a held request stays put until the monitor saw it accepted.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) pending_requests.delete(0);
      if (pending_requests.size() > 0 && !hold_send && !idle_roll(1'b1)) begin
        in_valid <= 1'b1;
        in_data  <= pending_requests[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= hold_recv || idle_roll(1'b0);
  end

  // Predict at acceptance, check results at the rising edge.
  always @(posedge clk) begin
    out_t exp_r;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_results.insert(expected_results.size(), predict_command(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result status=%0d pop_value=%0d",
                 out_data.status, out_data.pop_value);
          fail_count++;
        end else begin
          exp_r = expected_results[0];
          expected_results.delete(0);
          if (out_data.status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, out_data.status);
            fail_count++;
          end
          if (out_data.pop_value !== exp_r.pop_value) begin
            $error("pop_value expected %0d got %0d", exp_r.pop_value, out_data.pop_value);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic in_t make_cmd(logic [1:0] f, int q, int s, int side, logic [31:0] v);
    in_t c;
    c.func = f;
    c.queue_index = 4'(q);
    c.source_index = 4'(s);
    c.side_or_reverse = 1'(side);
    c.push_value = v;
    return c;
  endfunction

  function automatic void add_request(in_t c);
    pending_requests.insert(pending_requests.size(), c);
  endfunction

  // Mostly pushes and pops on a few busy queues, with occasional merges.
  function automatic in_t random_cmd();
    int pick;
    int q;
    pick = $urandom_range(99);
    q = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(3);
    if (pick < 50)
      return make_cmd(FN_PUSH, q, $urandom_range(15), $urandom_range(1), $urandom);
    if (pick < 85)
      return make_cmd(FN_POP, q, $urandom_range(15), $urandom_range(1), $urandom);
    if (pick < 97)
      return make_cmd(FN_MERGE, q, $urandom_range(15), $urandom_range(1), $urandom);
    return make_cmd(FN_UNUSED, q, $urandom_range(15), $urandom_range(1), $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    idle_mode = IDLE_NONE;
    hold_recv = 1'b0;
    hold_send = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: empty pops, extremes, both sides, unused code, merges.
    add_request(make_cmd(FN_POP, 0, 0, 0, 0));
    add_request(make_cmd(FN_POP, 15, 0, 1, 0));
    add_request(make_cmd(FN_PUSH, 0, 15, 0, 32'h8000_0000));
    add_request(make_cmd(FN_PUSH, 0, 0, 1, 32'h7fff_ffff));
    add_request(make_cmd(FN_PUSH, 0, 0, 1, 32'hffff_ffff));
    add_request(make_cmd(FN_PUSH, 15, 0, 0, 32'h0));
    add_request(make_cmd(FN_PUSH, 15, 0, 1, 32'h5555_aaaa));
    add_request(make_cmd(FN_UNUSED, 15, 15, 1, 32'hffff_ffff));
    add_request(make_cmd(FN_MERGE, 15, 0, 0, 0));
    add_request(make_cmd(FN_PUSH, 1, 0, 1, 32'd11));
    add_request(make_cmd(FN_PUSH, 1, 0, 1, 32'd22));
    add_request(make_cmd(FN_MERGE, 15, 1, 1, 0));
    add_request(make_cmd(FN_MERGE, 15, 15, 0, 0));
    add_request(make_cmd(FN_POP, 15, 0, 0, 0));
    for (int i = 0; i < CAP + 1; i++)
      add_request(make_cmd(FN_PUSH, 2, 0, i % 2, $urandom));
    add_request(make_cmd(FN_PUSH, 3, 0, 1, 32'd7));
    add_request(make_cmd(FN_MERGE, 2, 3, 0, 0));
    add_request(make_cmd(FN_POP, 2, 0, 1, 0));
    add_request(make_cmd(FN_MERGE, 2, 3, 1, 0));
    add_request(make_cmd(FN_MERGE, 4, 2, 0, 0));
    add_request(make_cmd(FN_MERGE, 4, 4, 1, 0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_t'(ph);
      for (int i = 0; i < 330; i++) add_request(random_cmd());
      if (ph == 1) begin
        // Long receiver hold-off while requests keep coming.
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      wait_drained();
    end
    // Sender pauses after a drain, then one more burst.
    hold_send = 1'b1;
    repeat (20) @(posedge clk);
    hold_send = 1'b0;
    for (int i = 0; i < 250; i++) add_request(random_cmd());
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mdqm_pkg.sv
hdl/mdqm_ctrl.sv
hdl/mdqm_datapath.sv
hdl/multi_deque_merge_engine.sv
verif/multi_deque_merge_engine_tb.sv
